// ===== src/i2c_master_transfer_sequencer_macros.svh =====
// Assertion macros used by the I2C master sequencer checker.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_MACROS_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define I2C_MTS_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define I2C_MTS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/i2c_mts_pkg.sv =====
// Types and constants shared by the I2C master transfer sequencer.
`timescale 1ns / 1ps

package i2c_mts_pkg;

   localparam int TICK_WIDTH = 16;
   localparam int TIMEOUT_WIDTH = 16;
   localparam int CMP_WIDTH = (TICK_WIDTH > TIMEOUT_WIDTH) ? TICK_WIDTH : TIMEOUT_WIDTH;
   localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET = TIMEOUT_WIDTH'(100);
   localparam logic [TICK_WIDTH-1:0] TICK_MAX = {TICK_WIDTH{1'b1}};

   localparam int REQ_DATA_WIDTH = 24;
   localparam int RSP_DATA_WIDTH = 32;

   // Sticky error bit positions
   localparam int ERR_ARB_BIT     = 0;
   localparam int ERR_BUS_BIT     = 1;
   localparam int ERR_TIMEOUT_BIT = 2;
   localparam int ERR_ADDR_BIT    = 3;
   localparam int ERR_DATA_BIT    = 4;

   localparam logic [7:0] READ_ERROR_BYTE = 8'hFF;

   typedef enum logic [1:0] {
      MODE_START = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_READ  = 2'd2,
      MODE_TICK  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CMD_NONE      = 3'd0,
      CMD_STOP      = 3'd1,
      CMD_NACK      = 3'd2,
      CMD_NACK_STOP = 3'd3,
      CMD_ACK_RECV  = 3'd4,
      CMD_RECV_STOP = 3'd5
   } cmd_type;

   typedef struct packed {
      mode_type   mode;
      logic [6:0] slave_address;
      logic       is_read;
      logic [7:0] data_byte;
      logic       last_byte;
      logic       send_stop;
      logic       arb_lost;
      logic       bus_error;
      logic       got_nack;
      logic       read_ready;
   } req_type;

   typedef struct packed {
      logic [7:0] address_byte;
      cmd_type    bus_command;
      logic       retry_start;
      logic       start_done;
      logic       abort_transfer;
      logic [7:0] read_data;
      logic [4:0] error_flags;
   } rsp_type;

   // Handshake status passed from the result stage back to the input stage.
   typedef struct packed {
      logic fire;
      logic take;
   } flow_type;

endpackage

// ===== src/i2c_mts_in_stage.sv =====
// Input register stage of the I2C master sequencer.
`timescale 1ns / 1ps

module i2c_mts_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  i2c_mts_pkg::req_type   req_item,
   input  i2c_mts_pkg::flow_type  flow,
   output logic                   item_valid,
   output i2c_mts_pkg::req_type   item
);

   logic                 valid_ff, valid_in;
   i2c_mts_pkg::req_type data_ff, data_in;
   logic                 load;

   assign req_tready = !valid_ff || flow.take;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = req_item;
      end else if (flow.fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign item_valid = valid_ff;
   assign item       = data_ff;

endmodule

// ===== src/i2c_mts_decide.sv =====
// Event decision logic and sequencer state of the I2C master.
`timescale 1ns / 1ps

module i2c_mts_decide (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [i2c_mts_pkg::TIMEOUT_WIDTH-1:0]  csr_wr_data,
   input  i2c_mts_pkg::req_type                   item,
   input  logic                                   item_fire,
   output i2c_mts_pkg::rsp_type                   result
);

   logic [i2c_mts_pkg::TIMEOUT_WIDTH-1:0] timeout_ff;
   logic [4:0]                            sticky_ff, sticky_in;
   logic                                  retrying_ff, retrying_in;
   logic [i2c_mts_pkg::TICK_WIDTH-1:0]    elapsed_ff, elapsed_in;
   logic [i2c_mts_pkg::TICK_WIDTH-1:0]    base_ticks;
   logic                                  fault;
   logic                                  stop;
   logic                                  timed_out;

   always_comb begin
      result      = '0;
      sticky_in   = sticky_ff;
      retrying_in = retrying_ff;
      elapsed_in  = elapsed_ff;
      stop        = 1'b0;
      fault       = item.arb_lost || item.bus_error;
      // A fresh start sequence restarts the tick count.
      base_ticks  = retrying_ff ? elapsed_ff : '0;
      timed_out   = i2c_mts_pkg::CMP_WIDTH'(base_ticks) >
                    i2c_mts_pkg::CMP_WIDTH'(timeout_ff);
      result.bus_command = i2c_mts_pkg::CMD_NONE;

      case (item.mode)
         i2c_mts_pkg::MODE_START: begin
            elapsed_in = base_ticks;
            result.address_byte = {item.slave_address, item.is_read};
            if (fault) begin
               sticky_in[i2c_mts_pkg::ERR_ARB_BIT] = sticky_ff[i2c_mts_pkg::ERR_ARB_BIT]
                                                     | item.arb_lost;
               sticky_in[i2c_mts_pkg::ERR_BUS_BIT] = sticky_ff[i2c_mts_pkg::ERR_BUS_BIT]
                                                     | item.bus_error;
               result.abort_transfer = 1'b1;
               result.bus_command    = i2c_mts_pkg::CMD_STOP;
               result.start_done     = 1'b1;
               retrying_in           = 1'b0;
            end else if (!item.got_nack) begin
               result.start_done = 1'b1;
               retrying_in       = 1'b0;
            end else if (!item.is_read) begin
               if (timed_out) begin
                  sticky_in[i2c_mts_pkg::ERR_TIMEOUT_BIT] = 1'b1;
                  result.bus_command = i2c_mts_pkg::CMD_STOP;
                  result.start_done  = 1'b1;
                  retrying_in        = 1'b0;
               end else begin
                  result.retry_start = 1'b1;
                  retrying_in        = 1'b1;
               end
            end else begin
               sticky_in[i2c_mts_pkg::ERR_ADDR_BIT] = 1'b1;
               result.bus_command = i2c_mts_pkg::CMD_STOP;
               result.start_done  = 1'b1;
               retrying_in        = 1'b0;
            end
         end
         i2c_mts_pkg::MODE_WRITE: begin
            retrying_in = 1'b0;
            if (fault) begin
               sticky_in[i2c_mts_pkg::ERR_ARB_BIT] = sticky_ff[i2c_mts_pkg::ERR_ARB_BIT]
                                                     | item.arb_lost;
               sticky_in[i2c_mts_pkg::ERR_BUS_BIT] = sticky_ff[i2c_mts_pkg::ERR_BUS_BIT]
                                                     | item.bus_error;
               stop = 1'b1;
            end else if (item.got_nack) begin
               sticky_in[i2c_mts_pkg::ERR_DATA_BIT] = 1'b1;
               stop = 1'b1;
            end
            // Error stop and final stop merge into one command.
            if (item.last_byte && item.send_stop) begin
               stop = 1'b1;
            end
            result.bus_command = stop ? i2c_mts_pkg::CMD_STOP : i2c_mts_pkg::CMD_NONE;
         end
         i2c_mts_pkg::MODE_READ: begin
            retrying_in = 1'b0;
            if (item.read_ready) begin
               result.read_data = item.data_byte;
               if (item.last_byte) begin
                  result.bus_command = item.send_stop ? i2c_mts_pkg::CMD_NACK_STOP
                                                      : i2c_mts_pkg::CMD_NACK;
               end else if (fault) begin
                  sticky_in[i2c_mts_pkg::ERR_ARB_BIT] = sticky_ff[i2c_mts_pkg::ERR_ARB_BIT]
                                                        | item.arb_lost;
                  sticky_in[i2c_mts_pkg::ERR_BUS_BIT] = sticky_ff[i2c_mts_pkg::ERR_BUS_BIT]
                                                        | item.bus_error;
                  result.bus_command = i2c_mts_pkg::CMD_RECV_STOP;
                  result.read_data   = i2c_mts_pkg::READ_ERROR_BYTE;
               end else begin
                  result.bus_command = i2c_mts_pkg::CMD_ACK_RECV;
               end
            end else begin
               sticky_in[i2c_mts_pkg::ERR_BUS_BIT] = 1'b1;
               result.bus_command = i2c_mts_pkg::CMD_STOP;
               result.read_data   = i2c_mts_pkg::READ_ERROR_BYTE;
            end
         end
         i2c_mts_pkg::MODE_TICK: begin
            // Saturate rather than wrap.
            if (elapsed_ff != i2c_mts_pkg::TICK_MAX) begin
               elapsed_in = elapsed_ff + 1'b1;
            end
         end
         default: begin
            elapsed_in = elapsed_ff;
         end
      endcase

      result.error_flags = sticky_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff  <= i2c_mts_pkg::TIMEOUT_RESET;
         sticky_ff   <= '0;
         retrying_ff <= 1'b0;
         elapsed_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
         if (item_fire) begin
            sticky_ff   <= sticky_in;
            retrying_ff <= retrying_in;
            elapsed_ff  <= elapsed_in;
         end
      end
   end

endmodule

// ===== src/i2c_mts_out_stage.sv =====
// Result register stage of the I2C master sequencer.
`timescale 1ns / 1ps

module i2c_mts_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  i2c_mts_pkg::rsp_type   result,
   output i2c_mts_pkg::flow_type  flow,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output i2c_mts_pkg::rsp_type   rsp_item
);

   logic                 valid_ff, valid_in;
   i2c_mts_pkg::rsp_type data_ff, data_in;
   logic                 take;

   assign take      = !valid_ff || rsp_tready;
   assign flow.take = take;
   assign flow.fire = item_valid && take;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (flow.fire) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_item   = data_ff;

endmodule

// ===== src/i2c_master_transfer_sequencer.sv =====
// Top level of the I2C master transfer sequencer.
`timescale 1ns / 1ps
//
//  Channel   Direction  Carries
//  req_*     in         one bus event: start, byte written, byte read, tick
//  rsp_*     out        one decision per event: address, command, marks, flags
//  csr_*     in         start timeout in ticks (write only)
//
//  The accepting edge loads the input register; the decision is then loaded
//  into the result register once the result side can take it. Throughput is one
//  request per cycle while the result side is not stalled; the decision path is
//  a few compares.
//  Reset clears sticky errors, retry state and tick count; timeout goes to 100.
//  A stalled result holds both stages; the input accepts again as soon as the
//  result register drains or is taken in the same cycle.

module i2c_master_transfer_sequencer (
   input  logic                                   clock,
   input  logic                                   reset,
   // Requests
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // [6:0] slave_address, [7] is_read, [15:8] data_byte, [16] send_stop,
   // [17] arb_lost, [18] bus_error, [19] got_nack, [20] read_ready, rest zero
   input  logic [i2c_mts_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   // [1:0] mode
   input  logic [1:0]                             req_tuser,
   // last_byte
   input  logic                                   req_tlast,
   // Results
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [7:0] address_byte, [10:8] bus_command, [11] retry_start, [12] start_done,
   // [13] abort_transfer, [21:14] read_data, [26:22] error_flags, rest zero
   output logic [i2c_mts_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // Configuration
   input  logic                                   csr_wr_en,
   input  logic [i2c_mts_pkg::TIMEOUT_WIDTH-1:0]  csr_wr_data
);

   i2c_mts_pkg::req_type  req_item;
   i2c_mts_pkg::req_type  item;
   i2c_mts_pkg::rsp_type  result;
   i2c_mts_pkg::rsp_type  rsp_item;
   i2c_mts_pkg::flow_type flow;
   logic                  item_valid;

   // Unpack the request bus into named fields.
   always_comb begin
      req_item.mode          = i2c_mts_pkg::mode_type'(req_tuser);
      req_item.slave_address = req_tdata[6:0];
      req_item.is_read       = req_tdata[7];
      req_item.data_byte     = req_tdata[15:8];
      req_item.last_byte     = req_tlast;
      req_item.send_stop     = req_tdata[16];
      req_item.arb_lost      = req_tdata[17];
      req_item.bus_error     = req_tdata[18];
      req_item.got_nack      = req_tdata[19];
      req_item.read_ready    = req_tdata[20];
   end

   i2c_mts_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .flow       (flow),
      .item_valid (item_valid),
      .item       (item)
   );

   // Advance sequencer state only when the decision lands in the result register.
   i2c_mts_decide u_decide (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item        (item),
      .item_fire   (flow.fire),
      .result      (result)
   );

   i2c_mts_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .result     (result),
      .flow       (flow),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   // Pack the result; pad the upper bits with zeros.
   assign rsp_tdata = {5'd0,
                       rsp_item.error_flags,
                       rsp_item.read_data,
                       rsp_item.abort_transfer,
                       rsp_item.start_done,
                       rsp_item.retry_start,
                       rsp_item.bus_command,
                       rsp_item.address_byte};

endmodule

// ===== src/i2c_mts_checker.sv =====
// Port-level assertions for the I2C master transfer sequencer, with bind.
`timescale 1ns / 1ps
`include "i2c_master_transfer_sequencer_macros.svh"

module i2c_mts_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   rsp_tvalid,
   input logic                                   rsp_tready,
   input logic [i2c_mts_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);

   `I2C_MTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   `I2C_MTS_ASSERT_NOW(a_retry_not_done, clock, reset, rsp_tvalid && rsp_tdata[11], !rsp_tdata[12] && rsp_tdata[10:8] == i2c_mts_pkg::CMD_NONE, "retry with done or command")

   `I2C_MTS_ASSERT_NOW(a_abort_stops, clock, reset, rsp_tvalid && rsp_tdata[13], rsp_tdata[12] && rsp_tdata[10:8] == i2c_mts_pkg::CMD_STOP, "abort without done and stop")

   `I2C_MTS_ASSERT_NOW(a_cmd_legal, clock, reset, rsp_tvalid, rsp_tdata[10:8] <= i2c_mts_pkg::CMD_RECV_STOP && rsp_tdata[31:27] == 5'd0, "illegal command or padding")

endmodule

bind i2c_master_transfer_sequencer i2c_mts_checker u_checker (.*);

// ===== test/tb_i2c_master_transfer_sequencer.sv =====
// Self-checking testbench for the I2C master transfer sequencer.
`timescale 1ns / 1ps

module tb_i2c_master_transfer_sequencer;

   // Tracks the sequencer's state on the side and holds the decisions still owed.
   class decision_scoreboard;
      logic [i2c_mts_pkg::TIMEOUT_WIDTH-1:0] timeout_ticks;
      logic [4:0]                            sticky_flags;
      bit                                    retry_pending;
      logic [i2c_mts_pkg::TICK_WIDTH-1:0]    ticks_seen;
      i2c_mts_pkg::rsp_type                  owed_decisions[$];
      int unsigned                           mismatches;

      function new();
         timeout_ticks = i2c_mts_pkg::TIMEOUT_RESET;
         sticky_flags  = '0;
         retry_pending = 1'b0;
         ticks_seen    = '0;
         mismatches    = 0;
      endfunction

      function void set_timeout(input logic [i2c_mts_pkg::TIMEOUT_WIDTH-1:0] value);
         timeout_ticks = value;
      endfunction

      function int unsigned pending();
         return owed_decisions.size();
      endfunction

      // Work out the decision for one accepted request and queue it.
      function void predict_decision(input i2c_mts_pkg::req_type r);
         i2c_mts_pkg::rsp_type d;
         bit                   stop_now;
         d        = '0;
         stop_now = 1'b0;
         case (r.mode)
            i2c_mts_pkg::MODE_START: begin
               if (!retry_pending) ticks_seen = '0;
               d.address_byte = {r.slave_address, r.is_read};
               if (r.arb_lost || r.bus_error) begin
                  if (r.arb_lost) sticky_flags[i2c_mts_pkg::ERR_ARB_BIT] = 1'b1;
                  if (r.bus_error) sticky_flags[i2c_mts_pkg::ERR_BUS_BIT] = 1'b1;
                  d.abort_transfer = 1'b1;
                  d.bus_command    = i2c_mts_pkg::CMD_STOP;
                  d.start_done     = 1'b1;
                  retry_pending    = 1'b0;
               end else if (!r.got_nack) begin
                  d.start_done  = 1'b1;
                  retry_pending = 1'b0;
               end else if (!r.is_read) begin
                  if (ticks_seen > timeout_ticks) begin
                     sticky_flags[i2c_mts_pkg::ERR_TIMEOUT_BIT] = 1'b1;
                     d.bus_command = i2c_mts_pkg::CMD_STOP;
                     d.start_done  = 1'b1;
                     retry_pending = 1'b0;
                  end else begin
                     d.retry_start = 1'b1;
                     retry_pending = 1'b1;
                  end
               end else begin
                  sticky_flags[i2c_mts_pkg::ERR_ADDR_BIT] = 1'b1;
                  d.bus_command = i2c_mts_pkg::CMD_STOP;
                  d.start_done  = 1'b1;
                  retry_pending = 1'b0;
               end
            end
            i2c_mts_pkg::MODE_WRITE: begin
               retry_pending = 1'b0;
               if (r.arb_lost || r.bus_error) begin
                  if (r.arb_lost) sticky_flags[i2c_mts_pkg::ERR_ARB_BIT] = 1'b1;
                  if (r.bus_error) sticky_flags[i2c_mts_pkg::ERR_BUS_BIT] = 1'b1;
                  stop_now = 1'b1;
               end else if (r.got_nack) begin
                  sticky_flags[i2c_mts_pkg::ERR_DATA_BIT] = 1'b1;
                  stop_now = 1'b1;
               end
               if (r.last_byte && r.send_stop) stop_now = 1'b1;
               d.bus_command = stop_now ? i2c_mts_pkg::CMD_STOP : i2c_mts_pkg::CMD_NONE;
            end
            i2c_mts_pkg::MODE_READ: begin
               retry_pending = 1'b0;
               if (r.read_ready) begin
                  d.read_data = r.data_byte;
                  if (r.last_byte) begin
                     d.bus_command = r.send_stop ? i2c_mts_pkg::CMD_NACK_STOP
                                                 : i2c_mts_pkg::CMD_NACK;
                  end else if (r.arb_lost || r.bus_error) begin
                     if (r.arb_lost) sticky_flags[i2c_mts_pkg::ERR_ARB_BIT] = 1'b1;
                     if (r.bus_error) sticky_flags[i2c_mts_pkg::ERR_BUS_BIT] = 1'b1;
                     d.bus_command = i2c_mts_pkg::CMD_RECV_STOP;
                     d.read_data   = i2c_mts_pkg::READ_ERROR_BYTE;
                  end else begin
                     d.bus_command = i2c_mts_pkg::CMD_ACK_RECV;
                  end
               end else begin
                  sticky_flags[i2c_mts_pkg::ERR_BUS_BIT] = 1'b1;
                  d.bus_command = i2c_mts_pkg::CMD_STOP;
                  d.read_data   = i2c_mts_pkg::READ_ERROR_BYTE;
               end
            end
            default: begin
               if (ticks_seen != i2c_mts_pkg::TICK_MAX) ticks_seen = ticks_seen + 1'b1;
            end
         endcase
         d.error_flags = sticky_flags;
         owed_decisions.push_back(d);
      endfunction

      function void compare_field(input string name, input logic [7:0] want,
                                  input logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
         end
      endfunction

      // Compare one delivered result against the oldest owed decision.
      function void check_decision(input logic [i2c_mts_pkg::RSP_DATA_WIDTH-1:0] word);
         i2c_mts_pkg::rsp_type want;
         if (owed_decisions.size() == 0) begin
            $error("result %h arrived with no request outstanding", word);
            mismatches++;
            return;
         end
         want = owed_decisions.pop_front();
         compare_field("address_byte", want.address_byte, word[7:0]);
         compare_field("bus_command", 8'(want.bus_command), 8'(word[10:8]));
         compare_field("retry_start", 8'(want.retry_start), 8'(word[11]));
         compare_field("start_done", 8'(want.start_done), 8'(word[12]));
         compare_field("abort_transfer", 8'(want.abort_transfer), 8'(word[13]));
         compare_field("read_data", want.read_data, word[21:14]);
         compare_field("error_flags", 8'(want.error_flags), 8'(word[26:22]));
      endfunction
   endclass

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_tvalid = 1'b0;
   logic                                   req_tready;
   logic [i2c_mts_pkg::REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic [1:0]                             req_tuser = '0;
   logic                                   req_tlast = 1'b0;
   logic                                   rsp_tvalid;
   logic                                   rsp_tready = 1'b0;
   logic [i2c_mts_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                                   csr_wr_en = 1'b0;
   logic [i2c_mts_pkg::TIMEOUT_WIDTH-1:0]  csr_wr_data = '0;

   decision_scoreboard decision_board = new();

   // Random idling on both channels; cleared for the closing stretch of the run.
   bit          idle_on = 1'b1;
   int unsigned sent_requests = 0;
   int unsigned stall_left = 0;

   i2c_master_transfer_sequencer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Result side: hold tready low in random bursts.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 5);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Sample at the falling edge: both handshake signals are settled there and
   // hold until the next rising edge, where the transfer actually happens.
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) decision_board.check_decision(rsp_tdata);
   end

   function automatic i2c_mts_pkg::req_type event_req(input i2c_mts_pkg::mode_type m,
                                                      input logic [6:0] a,
                                                      input logic rd, input logic [7:0] d,
                                                      input logic last, input logic stop,
                                                      input logic arb, input logic berr,
                                                      input logic nack, input logic ready);
      i2c_mts_pkg::req_type r;
      r.mode          = m;
      r.slave_address = a;
      r.is_read       = rd;
      r.data_byte     = d;
      r.last_byte     = last;
      r.send_stop     = stop;
      r.arb_lost      = arb;
      r.bus_error     = berr;
      r.got_nack      = nack;
      r.read_ready    = ready;
      return r;
   endfunction

   // Every field random; callers override what shapes the sequence.
   function automatic i2c_mts_pkg::req_type random_request(input i2c_mts_pkg::mode_type m);
      return event_req(m, 7'($urandom), 1'($urandom), 8'($urandom), 1'($urandom),
                       1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                       1'($urandom));
   endfunction

   // Present one request, optionally after an idle burst, and hold it until taken.
   // Called and returns at a rising edge.
   task automatic send_request(input i2c_mts_pkg::req_type r);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, r.read_ready, r.got_nack, r.bus_error, r.arb_lost,
                     r.send_stop, r.data_byte, r.is_read, r.slave_address};
      req_tuser  <= r.mode;
      req_tlast  <= r.last_byte;
      do @(negedge clock); while (!req_tready);
      decision_board.predict_decision(r);
      sent_requests++;
      @(posedge clock);
   endtask

   // Drop valid and hold off until every owed decision has been delivered.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (decision_board.pending() != 0);
   endtask

   // Only write the timeout register with the sequencer fully idle.
   task automatic write_timeout(input logic [i2c_mts_pkg::TIMEOUT_WIDTH-1:0] value);
      wait_for_drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      decision_board.set_timeout(value);
   endtask

   // One random bus activity: mostly well-formed, some noise.
   task automatic run_sequence();
      i2c_mts_pkg::req_type r;
      int unsigned          pick;
      int unsigned          len;
      logic [6:0]           addr;
      logic                 rd;
      pick = $urandom_range(0, 39);
      if (pick == 0) begin
         // Let the pipeline empty completely before carrying on.
         wait_for_drain();
      end else if (pick < 16) begin
         // Start with write-address NACK retries and ticks between attempts.
         addr = 7'($urandom);
         rd   = ($urandom_range(0, 3) == 0);
         len  = $urandom_range(1, 6);
         for (int i = 0; i < len; i++) begin
            r = random_request(i2c_mts_pkg::MODE_START);
            r.slave_address = addr;
            r.is_read       = rd;
            r.arb_lost      = ($urandom_range(0, 11) == 0);
            r.bus_error     = ($urandom_range(0, 11) == 0);
            r.got_nack      = (i + 1 < len) ? 1'b1 : 1'($urandom);
            send_request(r);
            repeat ($urandom_range(0, 4))
               send_request(random_request(i2c_mts_pkg::MODE_TICK));
         end
      end else if (pick < 24) begin
         // Byte writes closing with the last byte.
         len = $urandom_range(1, 5);
         for (int i = 0; i < len; i++) begin
            r = random_request(i2c_mts_pkg::MODE_WRITE);
            r.last_byte = (i + 1 == len);
            r.arb_lost  = ($urandom_range(0, 9) == 0);
            r.bus_error = ($urandom_range(0, 9) == 0);
            r.got_nack  = ($urandom_range(0, 9) == 0);
            send_request(r);
         end
      end else if (pick < 32) begin
         // Byte reads, mostly with data ready.
         len = $urandom_range(1, 5);
         for (int i = 0; i < len; i++) begin
            r = random_request(i2c_mts_pkg::MODE_READ);
            r.last_byte  = (i + 1 == len);
            r.read_ready = ($urandom_range(0, 7) != 0);
            r.arb_lost   = ($urandom_range(0, 9) == 0);
            r.bus_error  = ($urandom_range(0, 9) == 0);
            send_request(r);
         end
      end else if (pick < 36) begin
         repeat ($urandom_range(1, 8))
            send_request(random_request(i2c_mts_pkg::MODE_TICK));
      end else begin
         repeat ($urandom_range(1, 3))
            send_request(random_request(i2c_mts_pkg::mode_type'($urandom_range(0, 3))));
      end
   endtask

   task automatic run_phase(input int unsigned count);
      int unsigned target;
      target = sent_requests + count;
      while (sent_requests < target) run_sequence();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pass at the reset timeout.
      // First attempt, retry, tick, retry again, then a write abandons the retry.
      send_request(event_req(i2c_mts_pkg::MODE_START, 7'h55, 1'b0, 8'h00,
                             1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
      send_request(event_req(i2c_mts_pkg::MODE_TICK, 7'h00, 1'b0, 8'h00,
                             1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
      send_request(event_req(i2c_mts_pkg::MODE_START, 7'h55, 1'b0, 8'h00,
                             1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
      send_request(event_req(i2c_mts_pkg::MODE_WRITE, 7'h00, 1'b0, 8'hFF,
                             1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
      // Tick with every other field set: results stay zero apart from flags.
      send_request(event_req(i2c_mts_pkg::MODE_TICK, 7'h7F, 1'b1, 8'hFF,
                             1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
      send_request(event_req(i2c_mts_pkg::MODE_START, 7'h55, 1'b0, 8'h00,
                             1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
      // Arbitration lost outranks a NACK on start; a bus error on start aborts too.
      send_request(event_req(i2c_mts_pkg::MODE_START, 7'h7F, 1'b0, 8'h00,
                             1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
      send_request(event_req(i2c_mts_pkg::MODE_START, 7'h00, 1'b1, 8'h00,
                             1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
      send_request(event_req(i2c_mts_pkg::MODE_START, 7'h7F, 1'b1, 8'h00,
                             1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
      // Data NACK on the final byte: error stop and final stop merge into one.
      send_request(event_req(i2c_mts_pkg::MODE_WRITE, 7'h00, 1'b0, 8'h00,
                             1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0));
      send_request(event_req(i2c_mts_pkg::MODE_WRITE, 7'h00, 1'b0, 8'h81,
                             1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
      send_request(event_req(i2c_mts_pkg::MODE_WRITE, 7'h00, 1'b0, 8'h7E,
                             1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
      send_request(event_req(i2c_mts_pkg::MODE_WRITE, 7'h00, 1'b0, 8'h00,
                             1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
      // Reads: final byte with and without stop, failed next receive, not ready.
      send_request(event_req(i2c_mts_pkg::MODE_READ, 7'h00, 1'b0, 8'hFF,
                             1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
      send_request(event_req(i2c_mts_pkg::MODE_READ, 7'h00, 1'b0, 8'h00,
                             1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
      send_request(event_req(i2c_mts_pkg::MODE_READ, 7'h00, 1'b0, 8'h5A,
                             1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
      send_request(event_req(i2c_mts_pkg::MODE_READ, 7'h00, 1'b0, 8'hA5,
                             1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
      send_request(event_req(i2c_mts_pkg::MODE_READ, 7'h00, 1'b0, 8'h3C,
                             1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
      send_request(event_req(i2c_mts_pkg::MODE_READ, 7'h00, 1'b0, 8'hC3,
                             1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1));
      // Read-address NACK is an error, never a retry.
      send_request(event_req(i2c_mts_pkg::MODE_START, 7'h12, 1'b1, 8'h00,
                             1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
      send_request(event_req(i2c_mts_pkg::MODE_START, 7'h00, 1'b0, 8'h00,
                             1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));

      // Random phases across several timeout settings, extremes included.
      run_phase(200);
      write_timeout('0);
      run_phase(200);
      write_timeout('1);
      run_phase(150);
      write_timeout(i2c_mts_pkg::TIMEOUT_WIDTH'(3));
      run_phase(250);

      write_timeout(i2c_mts_pkg::TIMEOUT_WIDTH'($urandom_range(1, 20)));
      run_phase(250);
      write_timeout(i2c_mts_pkg::TIMEOUT_WIDTH'(12));
      run_phase(150);
      // Closing stretch at full rate on both sides.
      idle_on = 1'b0;
      run_phase(150);

      wait_for_drain();
      repeat (20) @(posedge clock);
      if (decision_board.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
